// ----- rtl/core/ogg_vorbis_page_verifier_macros.svh -----
// assertion helpers used by the checker file
`ifndef OGG_VORBIS_PAGE_VERIFIER_MACROS_SVH
`define OGG_VORBIS_PAGE_VERIFIER_MACROS_SVH

// clocked assertion, quiet while reset is held
`define OVPV_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// clocked assertion that must also hold during reset
`define OVPV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- rtl/core/ovpv_pkg.sv -----
package ovpv_pkg;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_MAGIC      = 3'd1;
  localparam logic [2:0] ST_TRUNCATED  = 3'd2;
  localparam logic [2:0] ST_VERSION    = 3'd3;
  localparam logic [2:0] ST_FORMAT     = 3'd4;
  localparam logic [2:0] ST_CORRUPTED  = 3'd5;
  localparam logic [2:0] ST_TOO_LONG   = 3'd6;
  localparam logic [2:0] ST_NOT_VORBIS = 3'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_GRANULE = 2'd0;
  localparam logic [1:0] CFG_CHANNELS    = 2'd1;
  localparam logic [1:0] CFG_SAMPLE_RATE = 2'd2;

  localparam logic [62:0] MAX_GRANULE_RST = 63'd441000;
  localparam logic [7:0]  CHANNELS_RST    = 8'd1;
  localparam logic [31:0] SAMPLE_RATE_RST = 32'd44100;

  localparam logic [16:0] IDENT_LEN     = 17'd30;
  localparam logic [3:0]  BLK_EXP_MIN   = 4'd6;
  localparam logic [3:0]  BLK_EXP_MAX   = 4'd13;
  localparam int unsigned FLAG_BOS_BIT  = 1;  // 0x2
  localparam int unsigned FLAG_EOS_BIT  = 2;  // 0x4

  // result word carried on the master tdata
  typedef struct packed {
    logic [3:0] pad;
    logic [2:0] status;
    logic       stream_done;
    logic [7:0] payload_byte;
  } out_data_t;

  // "OggS"
  function automatic logic [7:0] capture_byte(logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h4f;
      2'd1:    r = 8'h67;
      2'd2:    r = 8'h67;
      default: r = 8'h53;
    endcase
    return r;
  endfunction

  // "vorbis", indexed by ident header position 1..6
  function automatic logic [7:0] vorbis_tag(logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd1:    r = 8'h76;
      3'd2:    r = 8'h6f;
      3'd3:    r = 8'h72;
      3'd4:    r = 8'h62;
      3'd5:    r = 8'h69;
      3'd6:    r = 8'h73;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/ovpv_ident_chk.sv -----
// fault check for one byte of the vorbis identification header
module ovpv_ident_chk (
  input  logic [4:0]  pos_i,
  input  logic [7:0]  byte_i,
  input  logic [7:0]  req_channels_i,
  input  logic [31:0] req_rate_i,
  output logic [2:0]  err_o
);

  logic [7:0] rate_byte;

  assign rate_byte = req_rate_i[{pos_i[1:0], 3'b000} +: 8];

  always_comb begin
    err_o = ovpv_pkg::ST_OK;
    unique case (pos_i) inside
      5'd0: begin
        if (byte_i != 8'd1) err_o = ovpv_pkg::ST_NOT_VORBIS;
      end
      [5'd1:5'd6]: begin
        if (byte_i != ovpv_pkg::vorbis_tag(pos_i[2:0])) err_o = ovpv_pkg::ST_NOT_VORBIS;
      end
      [5'd7:5'd10]: begin
        if (byte_i != 8'd0) err_o = ovpv_pkg::ST_NOT_VORBIS;
      end
      5'd11: begin
        if (byte_i != req_channels_i) err_o = ovpv_pkg::ST_FORMAT;
      end
      [5'd12:5'd15]: begin
        if (byte_i != rate_byte) err_o = ovpv_pkg::ST_FORMAT;
      end
      5'd28: begin
        // low nibble is the short block exponent, high nibble the long one
        if (byte_i[3:0] > byte_i[7:4] || byte_i[7:4] > ovpv_pkg::BLK_EXP_MAX ||
            byte_i[3:0] < ovpv_pkg::BLK_EXP_MIN) err_o = ovpv_pkg::ST_CORRUPTED;
      end
      5'd29: begin
        if (!byte_i[0]) err_o = ovpv_pkg::ST_CORRUPTED;
      end
      default: err_o = ovpv_pkg::ST_OK;
    endcase
  end

endmodule

// ----- rtl/core/ogg_vorbis_page_verifier.sv -----
// Ogg page verifier for a single Vorbis stream. The file enters one byte per request on
// the slave stream (tdata = byte; tlast = end of file, the byte then being ignored). Each
// request yields exactly one result on the master stream, in the cycle after it is taken:
// tdata holds payload byte, stream_done and status, tuser flags a byte to hash and tlast
// marks a byte that completed a page. One byte is taken every cycle; the single result
// register stalls intake only while a result is held back by the sink. Errors are sticky:
// once status is nonzero every later result repeats it with all other fields zero. The user
// must write the configuration registers (max granule, channels, sample rate) through
// cfg_we_i / cfg_addr_i / cfg_wdata_i only while the stream is idle; the block does not check.
module ogg_vorbis_page_verifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [62:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tlast,   // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [8] stream_done, [11:9] status
  output logic        m_axis_tuser,   // payload_valid
  output logic        m_axis_tlast    // page_done
);

  localparam logic [2:0] PH_HEADER   = 3'd0;
  localparam logic [2:0] PH_SEGMENTS = 3'd1;
  localparam logic [2:0] PH_DATA     = 3'd2;
  localparam logic [2:0] PH_DONE     = 3'd3;
  localparam logic [2:0] PH_ERROR    = 3'd4;

  logic [62:0] max_granule_q;
  logic [7:0]  req_channels_q;
  logic [31:0] req_rate_q;

  logic [2:0]  phase_q, phase_d;
  logic [4:0]  hdr_pos_q, hdr_pos_d;
  logic [15:0] flags_ver_q, flags_ver_d;
  logic [63:0] granule_q, granule_d;
  logic [31:0] serial_q, serial_d;
  logic [31:0] seq_q, seq_d;
  logic [31:0] stored_serial_q, stored_serial_d;
  logic [31:0] exp_seq_q, exp_seq_d;
  logic [7:0]  seg_left_q, seg_left_d;
  logic [16:0] data_len_q, data_len_d;
  logic [16:0] data_pos_q, data_pos_d;
  logic        seen_first_q, seen_first_d;
  logic        seen_last_q, seen_last_d;
  logic        hashing_q, hashing_d;
  logic [2:0]  ident_err_q, ident_err_d;
  logic [2:0]  sticky_q, sticky_d;
  logic        magic_ok_q, magic_ok_d;
  logic        ident_page_q, ident_page_d;

  logic        out_valid_q;
  ovpv_pkg::out_data_t out_data_q, res_data;
  logic        out_user_q, out_last_q;
  logic        res_pv, res_pd, finish;

  logic        in_acc;
  logic [7:0]  b;
  logic        eoi;

  // page header check terms
  logic        bos, eos, seen_first_new;
  logic [31:0] exp_seq_new, stored_serial_new;
  logic [2:0]  hdr_err;

  // data phase terms
  logic [16:0] data_len_new, data_pos_new;
  logic [7:0]  seg_left_new;
  logic [2:0]  ident_chk_err, ident_err_now;
  logic [2:0]  gran_idx;
  logic [1:0]  word_idx;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign b             = s_axis_tdata;
  assign eoi           = s_axis_tlast;

  ovpv_ident_chk u_ident_chk (
    .pos_i          (data_pos_q[4:0]),
    .byte_i         (b),
    .req_channels_i (req_channels_q),
    .req_rate_i     (req_rate_q),
    .err_o          (ident_chk_err)
  );

  // header checks, in the order the format fixes
  always_comb begin
    bos               = flags_ver_q[8 + ovpv_pkg::FLAG_BOS_BIT];
    eos               = flags_ver_q[8 + ovpv_pkg::FLAG_EOS_BIT];
    seen_first_new    = seen_first_q || bos;
    exp_seq_new       = bos ? 32'd0 : exp_seq_q + 32'd1;
    stored_serial_new = (stored_serial_q == 32'd0) ? serial_q : stored_serial_q;
    hdr_err           = ovpv_pkg::ST_OK;
    if (!magic_ok_q) begin
      hdr_err = ovpv_pkg::ST_MAGIC;
    end else if (flags_ver_q[7:0] != 8'd0) begin
      hdr_err = ovpv_pkg::ST_VERSION;
    end else if (bos && seen_first_q) begin
      hdr_err = ovpv_pkg::ST_FORMAT;
    end else if (!seen_first_new) begin
      hdr_err = ovpv_pkg::ST_CORRUPTED;
    end else if (granule_q != '1 && granule_q > {1'b0, max_granule_q}) begin
      hdr_err = ovpv_pkg::ST_TOO_LONG;
    end else if (stored_serial_q != 32'd0 && serial_q != stored_serial_q) begin
      hdr_err = ovpv_pkg::ST_CORRUPTED;
    end else if (seq_q != exp_seq_new) begin
      hdr_err = ovpv_pkg::ST_CORRUPTED;
    end else if (exp_seq_new == 32'd0 && b != 8'd1) begin
      // ident page must carry exactly one segment
      hdr_err = ovpv_pkg::ST_NOT_VORBIS;
    end
  end

  assign data_len_new  = data_len_q + {9'd0, b};
  assign seg_left_new  = seg_left_q - 8'd1;
  assign data_pos_new  = data_pos_q + 17'd1;
  assign ident_err_now = (ident_err_q != ovpv_pkg::ST_OK) ? ident_err_q : ident_chk_err;
  assign gran_idx      = 3'(hdr_pos_q - 5'd6);
  assign word_idx      = hdr_pos_q[1:0] + 2'd2;  // 14..17 and 18..21 map to 0..3

  always_comb begin
    phase_d         = phase_q;
    hdr_pos_d       = hdr_pos_q;
    flags_ver_d     = flags_ver_q;
    granule_d       = granule_q;
    serial_d        = serial_q;
    seq_d           = seq_q;
    stored_serial_d = stored_serial_q;
    exp_seq_d       = exp_seq_q;
    seg_left_d      = seg_left_q;
    data_len_d      = data_len_q;
    data_pos_d      = data_pos_q;
    seen_first_d    = seen_first_q;
    seen_last_d     = seen_last_q;
    hashing_d       = hashing_q;
    ident_err_d     = ident_err_q;
    sticky_d        = sticky_q;
    magic_ok_d      = magic_ok_q;
    ident_page_d    = ident_page_q;
    res_data        = '0;
    res_pv          = 1'b0;
    res_pd          = 1'b0;
    finish          = 1'b0;

    if (in_acc) begin
      unique case (phase_q)
        PH_DONE: begin
          res_data.stream_done = 1'b1;
        end
        PH_HEADER: begin
          if (eoi) begin
            phase_d  = PH_ERROR;
            sticky_d = (hdr_pos_q < 5'd4 || !magic_ok_q) ? ovpv_pkg::ST_MAGIC
                                                          : ovpv_pkg::ST_TRUNCATED;
          end else begin
            if (hdr_pos_q < 5'd4) begin
              if (b != ovpv_pkg::capture_byte(hdr_pos_q[1:0])) magic_ok_d = 1'b0;
            end else if (hdr_pos_q == 5'd4) begin
              flags_ver_d[7:0] = b;
            end else if (hdr_pos_q == 5'd5) begin
              flags_ver_d[15:8] = b;
            end else if (hdr_pos_q < 5'd14) begin
              granule_d[{gran_idx, 3'b000} +: 8] = b;
            end else if (hdr_pos_q < 5'd18) begin
              serial_d[{word_idx, 3'b000} +: 8] = b;
            end else if (hdr_pos_q < 5'd22) begin
              seq_d[{word_idx, 3'b000} +: 8] = b;
            end
            if (hdr_pos_q < 5'd26) begin
              hdr_pos_d = hdr_pos_q + 5'd1;
            end else if (hdr_err != ovpv_pkg::ST_OK) begin
              phase_d  = PH_ERROR;
              sticky_d = hdr_err;
            end else begin
              seen_first_d    = seen_first_new;
              exp_seq_d       = exp_seq_new;
              seen_last_d     = seen_last_q || eos;
              stored_serial_d = stored_serial_new;
              ident_page_d    = (exp_seq_new == 32'd0);
              if (granule_q != 64'd0) hashing_d = 1'b1;
              seg_left_d  = b;
              data_len_d  = '0;
              ident_err_d = ovpv_pkg::ST_OK;
              if (b == 8'd0) finish = 1'b1;
              else phase_d = PH_SEGMENTS;
            end
          end
        end
        PH_SEGMENTS: begin
          if (eoi) begin
            phase_d  = PH_ERROR;
            sticky_d = ovpv_pkg::ST_CORRUPTED;
          end else begin
            data_len_d = data_len_new;
            seg_left_d = seg_left_new;
            if (seg_left_new == 8'd0) begin
              if (ident_page_q && data_len_new != ovpv_pkg::IDENT_LEN) begin
                phase_d  = PH_ERROR;
                sticky_d = ovpv_pkg::ST_NOT_VORBIS;
              end else if (data_len_new == 17'd0) begin
                finish = 1'b1;
              end else begin
                phase_d    = PH_DATA;
                data_pos_d = '0;
              end
            end
          end
        end
        PH_DATA: begin
          if (eoi) begin
            phase_d  = PH_ERROR;
            sticky_d = ovpv_pkg::ST_CORRUPTED;
          end else begin
            if (hashing_q) begin
              res_pv                = 1'b1;
              res_data.payload_byte = b;
            end
            if (ident_page_q) ident_err_d = ident_err_now;
            data_pos_d = data_pos_new;
            if (data_pos_new >= data_len_q) begin
              if (ident_page_q && ident_err_now != ovpv_pkg::ST_OK) begin
                phase_d  = PH_ERROR;
                sticky_d = ident_err_now;
              end else begin
                finish = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase

      if (finish) begin
        res_pd = 1'b1;
        if (hashing_d && seen_last_d) begin
          res_data.stream_done = 1'b1;
          phase_d              = PH_DONE;
        end else begin
          phase_d    = PH_HEADER;
          hdr_pos_d  = '0;
          magic_ok_d = 1'b1;
        end
      end

      if (phase_d == PH_ERROR) begin
        res_data = '0;
        res_pv   = 1'b0;
        res_pd   = 1'b0;
      end
      res_data.status = sticky_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_granule_q  <= ovpv_pkg::MAX_GRANULE_RST;
      req_channels_q <= ovpv_pkg::CHANNELS_RST;
      req_rate_q     <= ovpv_pkg::SAMPLE_RATE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ovpv_pkg::CFG_MAX_GRANULE: max_granule_q  <= cfg_wdata_i;
        ovpv_pkg::CFG_CHANNELS:    req_channels_q <= cfg_wdata_i[7:0];
        ovpv_pkg::CFG_SAMPLE_RATE: req_rate_q     <= cfg_wdata_i[31:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_HEADER;
      hdr_pos_q       <= '0;
      flags_ver_q     <= '0;
      granule_q       <= '0;
      serial_q        <= '0;
      seq_q           <= '0;
      stored_serial_q <= '0;
      exp_seq_q       <= '0;
      seg_left_q      <= '0;
      data_len_q      <= '0;
      data_pos_q      <= '0;
      seen_first_q    <= 1'b0;
      seen_last_q     <= 1'b0;
      hashing_q       <= 1'b0;
      ident_err_q     <= '0;
      sticky_q        <= '0;
      magic_ok_q      <= 1'b1;
      ident_page_q    <= 1'b0;
    end else begin
      phase_q         <= phase_d;
      hdr_pos_q       <= hdr_pos_d;
      flags_ver_q     <= flags_ver_d;
      granule_q       <= granule_d;
      serial_q        <= serial_d;
      seq_q           <= seq_d;
      stored_serial_q <= stored_serial_d;
      exp_seq_q       <= exp_seq_d;
      seg_left_q      <= seg_left_d;
      data_len_q      <= data_len_d;
      data_pos_q      <= data_pos_d;
      seen_first_q    <= seen_first_d;
      seen_last_q     <= seen_last_d;
      hashing_q       <= hashing_d;
      ident_err_q     <= ident_err_d;
      sticky_q        <= sticky_d;
      magic_ok_q      <= magic_ok_d;
      ident_page_q    <= ident_page_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= res_data;
      out_user_q <= res_pv;
      out_last_q <= res_pd;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ----- rtl/core/ovpv_checker.sv -----
`include "ogg_vorbis_page_verifier_macros.svh"

module ovpv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  ovpv_pkg::out_data_t res;

  assign res = m_axis_tdata;

  // held result stays put
  `OVPV_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
    "stalled result changed")

  // every taken request leaves a result behind
  `OVPV_ASSERT(a_request_result, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid,
    "taken request left no result")

  // empty result register never blocks intake
  `OVPV_ASSERT_ALWAYS(a_ready_when_empty, clk_i,
    !m_axis_tvalid |-> s_axis_tready,
    "input stalled with empty result register")

  // an error result carries nothing else
  `OVPV_ASSERT(a_error_quiet, clk_i, rst_ni,
    m_axis_tvalid && res.status != ovpv_pkg::ST_OK |->
      !m_axis_tuser && !m_axis_tlast && !res.stream_done,
    "error result with payload, page or stream flag")

  // bytes not for hashing read as zero
  `OVPV_ASSERT(a_payload_zero, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tuser |-> res.payload_byte == 8'd0,
    "nonzero payload byte without payload flag")

endmodule

bind ogg_vorbis_page_verifier ovpv_checker u_ovpv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- bench/ogg_vorbis_page_verifier_tb.sv -----
`timescale 1ns / 100ps

module ogg_vorbis_page_verifier_tb;

  typedef enum logic [2:0] {
    PARSE_HEADER,
    PARSE_SEGMENTS,
    PARSE_DATA,
    PARSE_DONE,
    PARSE_ERROR
  } parse_phase_e;

  // how the file ends; the last five spoil the first page
  typedef enum int {
    END_CLEAN,
    END_EOI_MAGIC,
    END_EOI_HEADER,
    END_BAD_MAGIC,
    END_BAD_MAGIC_EOI,
    END_VERSION,
    END_BOS_AGAIN,
    END_GRANULE,
    END_SERIAL,
    END_SEQUENCE,
    END_EOI_SEGMENTS,
    END_EOI_DATA,
    END_NO_BOS,
    END_IDENT_SEGS,
    END_IDENT_LENGTH,
    END_IDENT_BYTE,
    END_IDENT_BYTE_EOI
  } stream_end_e;

  typedef struct packed {
    logic [7:0] payload;
    logic       pv;
    logic       pd;
    logic       sd;
    logic [2:0] status;
  } page_result_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
  } file_item_t;

  function automatic logic [7:0] ogg_capture(int unsigned i);
    case (i)
      0:       return 8'h4f;
      1, 2:    return 8'h67;
      default: return 8'h53;
    endcase
  endfunction

  function automatic logic [7:0] vorbis_letter(int unsigned i);
    case (i)
      1:       return 8'h76;
      2:       return 8'h6f;
      3:       return 8'h72;
      4:       return 8'h62;
      5:       return 8'h69;
      default: return 8'h73;
    endcase
  endfunction

  class ogg_page_model;
    logic [62:0]  max_granule;
    logic [7:0]   req_channels;
    logic [31:0]  req_rate;
    parse_phase_e phase;
    int unsigned  hdr_pos;
    logic [7:0]   flags;
    logic [7:0]   version;
    logic [63:0]  granule;
    logic [31:0]  serial;
    logic [31:0]  seq;
    logic [31:0]  stream_serial;
    logic [31:0]  next_seq;
    logic [7:0]   segs_left;
    logic [16:0]  data_len;
    logic [16:0]  data_pos;
    bit           got_bos;
    bit           got_eos;
    bit           hashing;
    bit           magic_ok;
    bit           ident_page;
    logic [2:0]   ident_err;
    logic [2:0]   sticky;
    page_result_t expected_results[$];
    int unsigned  mismatches;

    function new();
      max_granule   = ovpv_pkg::MAX_GRANULE_RST;
      req_channels  = ovpv_pkg::CHANNELS_RST;
      req_rate      = ovpv_pkg::SAMPLE_RATE_RST;
      phase         = PARSE_HEADER;
      hdr_pos       = 0;
      flags         = '0;
      version       = '0;
      granule       = '0;
      serial        = '0;
      seq           = '0;
      stream_serial = '0;
      next_seq      = '0;
      segs_left     = '0;
      data_len      = '0;
      data_pos      = '0;
      got_bos       = 0;
      got_eos       = 0;
      hashing       = 0;
      magic_ok      = 1;
      ident_page    = 0;
      ident_err     = ovpv_pkg::ST_OK;
      sticky        = ovpv_pkg::ST_OK;
      mismatches    = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [62:0] v);
      case (idx)
        ovpv_pkg::CFG_MAX_GRANULE: max_granule = v;
        ovpv_pkg::CFG_CHANNELS:    req_channels = v[7:0];
        ovpv_pkg::CFG_SAMPLE_RATE: req_rate = v[31:0];
        default: ;
      endcase
    endfunction

    function void close_page(inout page_result_t r);
      r.pd = 1'b1;
      if (hashing && got_eos) begin
        r.sd  = 1'b1;
        phase = PARSE_DONE;
      end else begin
        phase    = PARSE_HEADER;
        hdr_pos  = 0;
        magic_ok = 1;
      end
    endfunction

    function void take_byte(logic [7:0] b, logic eoi);
      page_result_t r;
      logic [2:0]   e;
      r = '0;
      case (phase)
        PARSE_DONE: r.sd = 1'b1;
        PARSE_HEADER: begin
          if (eoi) begin
            sticky = (hdr_pos < 4 || !magic_ok) ? ovpv_pkg::ST_MAGIC : ovpv_pkg::ST_TRUNCATED;
            phase  = PARSE_ERROR;
          end else begin
            if (hdr_pos == 0) begin
              granule = '0;
              serial  = '0;
              seq     = '0;
              flags   = '0;
              version = '0;
            end
            if (hdr_pos < 4) begin
              if (b != ogg_capture(hdr_pos)) magic_ok = 0;
            end else if (hdr_pos == 4) version = b;
            else if (hdr_pos == 5) flags = b;
            else if (hdr_pos < 14) granule[8*(hdr_pos-6) +: 8] = b;
            else if (hdr_pos < 18) serial[8*(hdr_pos-14) +: 8] = b;
            else if (hdr_pos < 22) seq[8*(hdr_pos-18) +: 8] = b;
            if (hdr_pos < 26) begin
              hdr_pos++;
            end else begin
              // page header checks, in the order the format defines them
              e = ovpv_pkg::ST_OK;
              if (!magic_ok) e = ovpv_pkg::ST_MAGIC;
              else if (version != 8'd0) e = ovpv_pkg::ST_VERSION;
              else begin
                if (flags[ovpv_pkg::FLAG_BOS_BIT]) begin
                  if (got_bos) e = ovpv_pkg::ST_FORMAT;
                  else begin
                    got_bos  = 1;
                    next_seq = '0;
                  end
                end else begin
                  next_seq = next_seq + 32'd1;
                end
                if (e == ovpv_pkg::ST_OK) begin
                  if (flags[ovpv_pkg::FLAG_EOS_BIT]) got_eos = 1;
                  if (!got_bos) e = ovpv_pkg::ST_CORRUPTED;
                  else if (granule != '1 && granule > {1'b0, max_granule})
                    e = ovpv_pkg::ST_TOO_LONG;
                  else begin
                    if (stream_serial == '0) stream_serial = serial;
                    else if (serial != stream_serial) e = ovpv_pkg::ST_CORRUPTED;
                    if (e == ovpv_pkg::ST_OK && seq != next_seq) e = ovpv_pkg::ST_CORRUPTED;
                  end
                end
              end
              ident_page = (next_seq == '0);
              if (e == ovpv_pkg::ST_OK && ident_page && b != 8'd1) e = ovpv_pkg::ST_NOT_VORBIS;
              if (e != ovpv_pkg::ST_OK) begin
                sticky = e;
                phase  = PARSE_ERROR;
              end else begin
                if (granule != '0) hashing = 1;
                segs_left = b;
                data_len  = '0;
                ident_err = ovpv_pkg::ST_OK;
                if (b == 8'd0) close_page(r);
                else phase = PARSE_SEGMENTS;
              end
            end
          end
        end
        PARSE_SEGMENTS: begin
          if (eoi) begin
            sticky = ovpv_pkg::ST_CORRUPTED;
            phase  = PARSE_ERROR;
          end else begin
            data_len  = data_len + 17'(b);
            segs_left = segs_left - 8'd1;
            if (segs_left == 8'd0) begin
              if (ident_page && data_len != ovpv_pkg::IDENT_LEN) begin
                sticky = ovpv_pkg::ST_NOT_VORBIS;
                phase  = PARSE_ERROR;
              end else if (data_len == '0) begin
                close_page(r);
              end else begin
                phase    = PARSE_DATA;
                data_pos = '0;
              end
            end
          end
        end
        PARSE_DATA: begin
          if (eoi) begin
            sticky = ovpv_pkg::ST_CORRUPTED;
            phase  = PARSE_ERROR;
          end else begin
            if (hashing) begin
              r.pv      = 1'b1;
              r.payload = b;
            end
            // identification header fields, first fault wins
            if (ident_page && ident_err == ovpv_pkg::ST_OK) begin
              e = ovpv_pkg::ST_OK;
              if (data_pos == 0) begin
                if (b != 8'd1) e = ovpv_pkg::ST_NOT_VORBIS;
              end else if (data_pos <= 6) begin
                if (b != vorbis_letter(data_pos)) e = ovpv_pkg::ST_NOT_VORBIS;
              end else if (data_pos <= 10) begin
                if (b != 8'd0) e = ovpv_pkg::ST_NOT_VORBIS;
              end else if (data_pos == 11) begin
                if (b != req_channels) e = ovpv_pkg::ST_FORMAT;
              end else if (data_pos <= 15) begin
                if (b != req_rate[8*(data_pos-12) +: 8]) e = ovpv_pkg::ST_FORMAT;
              end else if (data_pos == 28) begin
                if (b[3:0] > b[7:4] || b[7:4] > ovpv_pkg::BLK_EXP_MAX ||
                    b[3:0] < ovpv_pkg::BLK_EXP_MIN)
                  e = ovpv_pkg::ST_CORRUPTED;
              end else if (data_pos == 29) begin
                if (!b[0]) e = ovpv_pkg::ST_CORRUPTED;
              end
              ident_err = e;
            end
            data_pos = data_pos + 17'd1;
            if (data_pos >= data_len) begin
              if (ident_page && ident_err != ovpv_pkg::ST_OK) begin
                sticky = ident_err;
                phase  = PARSE_ERROR;
              end else begin
                close_page(r);
              end
            end
          end
        end
        default: ;
      endcase
      if (phase == PARSE_ERROR) r = '0;
      r.status = sticky;
      expected_results.push_back(r);
    endfunction

    function void match_result(page_result_t got);
      page_result_t want;
      if (expected_results.size() == 0) begin
        $error("result with no request pending: tdata %0h", got);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (got.payload !== want.payload) begin
        $error("payload_byte: expected %0h, got %0h", want.payload, got.payload);
        mismatches++;
      end
      if (got.pv !== want.pv) begin
        $error("payload_valid: expected %0b, got %0b", want.pv, got.pv);
        mismatches++;
      end
      if (got.pd !== want.pd) begin
        $error("page_done: expected %0b, got %0b", want.pd, got.pd);
        mismatches++;
      end
      if (got.sd !== want.sd) begin
        $error("stream_done: expected %0b, got %0b", want.sd, got.sd);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_addr_i;
  logic [62:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] byte_value
  logic        s_axis_tlast;   // end_of_input
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] payload_byte, [8] stream_done, [11:9] status
  logic        m_axis_tuser;   // payload_valid
  logic        m_axis_tlast;   // page_done

  ogg_vorbis_page_verifier uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  ogg_page_model book = new();
  file_item_t    page_items[$];
  bit            in_taken;
  int unsigned   sent_count;
  int unsigned   idle_pct;
  int unsigned   stall_pct;
  logic [31:0]   serial_no;
  logic [62:0]   cur_max;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("ogg_vorbis_page_verifier_tb: errors");
    $finish;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // requests are booked before results so a same-edge result still finds its entry
  always @(posedge clk_i) begin
    in_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_taken) book.take_byte(s_axis_tdata, s_axis_tlast);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      book.match_result('{payload: m_axis_tdata[7:0], pv: m_axis_tuser, pd: m_axis_tlast,
                          sd: m_axis_tdata[8], status: m_axis_tdata[11:9]});
  end

  task automatic set_idling(input int unsigned n);
    case (n % 5)
      1:       begin idle_pct = 88; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 88; end
      3:       begin idle_pct = 22; stall_pct = 22; end
      default: begin idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  task automatic send_item(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eoi;
    do @(negedge clk_i); while (!in_taken);
    sent_count++;
  endtask

  task automatic send_page();
    foreach (page_items[i]) send_item(page_items[i].b, page_items[i].eoi);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (book.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [62:0] v);
    cfg_addr_i  <= idx;
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    book.set_register(idx, v);
  endtask

  task automatic pick_settings();
    logic [62:0] v;
    case ($urandom_range(4))
      0:       v = '0;
      1:       v = '1;
      2:       v = 63'(ovpv_pkg::MAX_GRANULE_RST);
      3:       v = 63'($urandom);
      default: v = 63'({$urandom, $urandom});
    endcase
    cur_max = v;
    write_reg(ovpv_pkg::CFG_MAX_GRANULE, v);
    case ($urandom_range(3))
      0:       v = 63'(8'd0);
      1:       v = 63'(8'hff);
      2:       v = 63'(ovpv_pkg::CHANNELS_RST);
      default: v = 63'(8'($urandom));
    endcase
    write_reg(ovpv_pkg::CFG_CHANNELS, v);
    case ($urandom_range(3))
      0:       v = 63'(32'd0);
      1:       v = 63'(32'hffff_ffff);
      2:       v = 63'(ovpv_pkg::SAMPLE_RATE_RST);
      default: v = 63'($urandom);
    endcase
    write_reg(ovpv_pkg::CFG_SAMPLE_RATE, v);
  endtask

  function automatic void push_byte(input logic [7:0] b);
    page_items.push_back('{b: b, eoi: 1'b0});
  endfunction

  // drop everything from index k on and end the file there
  function automatic void cut_at(input int unsigned k);
    while (page_items.size() > k) void'(page_items.pop_back());
    page_items.push_back('{b: 8'($urandom), eoi: 1'b1});
  endfunction

  task automatic build_page(input logic [7:0] flags, input logic [63:0] gran,
                            input logic [31:0] sq, input bit ident, input bit need_data);
    int unsigned nseg;
    int unsigned r;
    int unsigned total;
    logic [7:0]  lens[$];
    logic [3:0]  lo;
    logic [3:0]  hi;
    page_items.delete();
    for (int i = 0; i < 4; i++) push_byte(ogg_capture(i));
    push_byte(8'd0);
    push_byte(flags);
    for (int i = 0; i < 8; i++) push_byte(gran[8*i +: 8]);
    for (int i = 0; i < 4; i++) push_byte(serial_no[8*i +: 8]);
    for (int i = 0; i < 4; i++) push_byte(sq[8*i +: 8]);
    for (int i = 0; i < 4; i++) push_byte(8'($urandom));  // checksum is not verified
    if (ident) begin
      lens.push_back(8'(ovpv_pkg::IDENT_LEN));
    end else begin
      if ($urandom_range(19) == 0) nseg = $urandom_range(255, 20);
      else nseg = $urandom_range(4);
      if (need_data && nseg == 0) nseg = 1;
      for (int i = 0; i < nseg; i++) begin
        r = $urandom_range(39);
        if (nseg > 16) lens.push_back(8'($urandom_range(2)));
        else if (r == 0) lens.push_back(8'hff);
        else if (r < 10) lens.push_back(8'd0);
        else lens.push_back(8'($urandom_range(12, 1)));
      end
      if (need_data && lens[0] == 8'd0) lens[0] = 8'd1;
    end
    push_byte(8'(lens.size()));
    total = 0;
    foreach (lens[i]) begin
      push_byte(lens[i]);
      total += lens[i];
    end
    if (ident) begin
      push_byte(8'd1);
      for (int i = 1; i <= 6; i++) push_byte(vorbis_letter(i));
      for (int i = 0; i < 4; i++) push_byte(8'd0);
      push_byte(book.req_channels);
      for (int i = 0; i < 4; i++) push_byte(book.req_rate[8*i +: 8]);
      for (int i = 16; i < 28; i++) push_byte(8'($urandom));  // bitrates
      lo = 4'($urandom_range(13, 6));
      hi = 4'($urandom_range(13, lo));
      push_byte({hi, lo});
      push_byte({7'($urandom), 1'b1});
    end else begin
      for (int i = 0; i < total; i++) push_byte(8'($urandom));
    end
  endtask

  function automatic logic [63:0] pick_granule();
    if (cur_max == '0 || $urandom_range(9) == 0) return '1;
    return ({$urandom, $urandom} % {1'b0, cur_max}) + 64'd1;
  endfunction

  initial begin
    stream_end_e  ending;
    int unsigned  n;
    int unsigned  k;
    int unsigned  nseg;
    int unsigned  total;
    logic [7:0]   flags;
    logic [7:0]   v;
    logic [63:0]  gran;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = ovpv_pkg::CFG_MAX_GRANULE;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    sent_count    = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    pick_settings();
    if ($urandom_range(1) == 0) ending = END_CLEAN;
    else ending = stream_end_e'($urandom_range(END_IDENT_BYTE_EOI, END_EOI_MAGIC));
    serial_no = ($urandom_range(7) == 0) ? 32'd0 : $urandom;

    // first page: the identification header
    flags = 8'($urandom) & ~(8'd1 << ovpv_pkg::FLAG_EOS_BIT);
    flags[ovpv_pkg::FLAG_BOS_BIT] = 1'b1;
    build_page(flags, '0, '0, 1, 0);
    case (ending)
      END_NO_BOS: page_items[5].b[ovpv_pkg::FLAG_BOS_BIT] = 1'b0;
      END_IDENT_SEGS: begin
        do v = 8'($urandom); while (v == 8'd1);
        page_items[26].b = v;
      end
      END_IDENT_LENGTH: begin
        do v = 8'($urandom); while (v == 8'(ovpv_pkg::IDENT_LEN));
        page_items[27].b = v;
      end
      END_IDENT_BYTE, END_IDENT_BYTE_EOI: begin
        k = $urandom_range(17);
        if (k == 16) k = 28;
        else if (k == 17) k = 29;
        if (k == 28) begin
          do v = 8'($urandom);
          while (v[3:0] >= ovpv_pkg::BLK_EXP_MIN && v[3:0] <= v[7:4] &&
                 v[7:4] <= ovpv_pkg::BLK_EXP_MAX);
          page_items[28+k].b = v;
        end else if (k == 29) begin
          page_items[28+k].b[0] = 1'b0;
        end else begin
          page_items[28+k].b ^= 8'($urandom_range(255, 1));
        end
        // truncation inside the data outranks the header fault
        if (ending == END_IDENT_BYTE_EOI) cut_at(28 + $urandom_range(29, k + 1));
      end
      default: ;
    endcase
    send_page();

    if (ending < END_NO_BOS) begin
      n = 1;
      while (sent_count < 1400) begin
        set_idling(n);
        if (n % 4 == 0) begin
          wait_idle();
          pick_settings();
        end
        gran  = (n < 3) ? 64'd0 : pick_granule();
        flags = 8'($urandom) &
                ~((8'd1 << ovpv_pkg::FLAG_BOS_BIT) | (8'd1 << ovpv_pkg::FLAG_EOS_BIT));
        build_page(flags, gran, n, 0, 0);
        send_page();
        n++;
      end

      // last page: ends the stream cleanly or breaks it
      idle_pct  = 22 * $urandom_range(1);
      stall_pct = 22 * $urandom_range(1);
      flags = 8'($urandom) &
              ~((8'd1 << ovpv_pkg::FLAG_BOS_BIT) | (8'd1 << ovpv_pkg::FLAG_EOS_BIT));
      if (ending == END_CLEAN) flags[ovpv_pkg::FLAG_EOS_BIT] = 1'b1;
      if (ending == END_BOS_AGAIN) flags[ovpv_pkg::FLAG_BOS_BIT] = 1'b1;
      gran = pick_granule();
      if (ending == END_GRANULE) gran = {1'b0, cur_max} + 64'($urandom_range(3, 1));
      build_page(flags, gran, n, 0, ending == END_EOI_SEGMENTS || ending == END_EOI_DATA);
      nseg  = page_items[26].b;
      total = page_items.size() - 27 - nseg;
      case (ending)
        END_EOI_MAGIC:  cut_at($urandom_range(3));
        END_EOI_HEADER: cut_at($urandom_range(26, 4));
        END_BAD_MAGIC, END_BAD_MAGIC_EOI: begin
          k = $urandom_range(3);
          page_items[k].b ^= 8'($urandom_range(255, 1));
          if (ending == END_BAD_MAGIC_EOI) cut_at($urandom_range(26, k + 1));
        end
        END_VERSION:  page_items[4].b = 8'($urandom_range(255, 1));
        END_SERIAL: begin
          k = $urandom_range(31);
          page_items[14 + k/8].b[k%8] ^= 1'b1;
        end
        END_SEQUENCE: begin
          k = $urandom_range(31);
          page_items[18 + k/8].b[k%8] ^= 1'b1;
        end
        END_EOI_SEGMENTS: cut_at(27 + $urandom_range(nseg - 1));
        END_EOI_DATA:     cut_at(27 + nseg + $urandom_range(total - 1));
        default: ;
      endcase
      send_page();
    end

    // trailing noise, ignored once the stream has ended or failed
    n = 1;
    do begin
      set_idling(n);
      repeat ($urandom_range(60, 20)) send_item(8'($urandom), $urandom_range(2) == 0);
      n++;
    end while (sent_count < 1400);

    wait_idle();
    repeat (20) @(negedge clk_i);
    if (book.pending() != 0) begin
      $error("%0d results never arrived", book.pending());
      book.mismatches++;
    end
    if (book.mismatches == 0)
      $display("ogg_vorbis_page_verifier_tb: clean");
    else
      $display("ogg_vorbis_page_verifier_tb: errors");
    $finish;
  end

endmodule
